/* rtl/b58enc_pkg.sv */
package b58enc_pkg;

  localparam int unsigned NumWidth  = 32;
  localparam int unsigned DigWidth  = 6;
  localparam int unsigned SymWidth  = 7;
  localparam int unsigned MaxDigits = 6;
  localparam int unsigned CntWidth  = 3;

  // floor(x / 58) == (x * Recip) >> RecipShift for every 32-bit x
  localparam logic [NumWidth-1:0] Recip      = 32'd2369637129;
  localparam int unsigned         RecipShift = 37;
  localparam int unsigned         QuotWidth  = 2 * NumWidth - RecipShift;

  localparam logic [58*8-1:0] Alphabet =
    "123456789abcdefghijkmnopqrstuvwxyzABCDEFGHJKLMNPQRSTUVWXYZ";

  typedef struct packed {
    logic load;
    logic mul;
    logic div;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic quot_zero;
    logic last_digit;
  } sts_t;

  function automatic logic [SymWidth-1:0] b58_char(input logic [DigWidth-1:0] d);
    logic [8:0] ofs;
    ofs = {6'd57 - d, 3'b000};
    return Alphabet[ofs +: SymWidth];
  endfunction

endpackage

/* rtl/b58enc_ctrl.sv */
module b58enc_ctrl import b58enc_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start,
  output logic busy,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  typedef enum logic [3:0] {
    StIdle = 4'b0001,
    StMul  = 4'b0010,
    StDiv  = 4'b0100,
    StEmit = 4'b1000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      StIdle: begin
        if (start) begin
          cmd_o.load = 1'b1;
          state_d    = StMul;
        end
      end
      StMul: begin
        cmd_o.mul = 1'b1;
        state_d   = StDiv;
      end
      StDiv: begin
        cmd_o.div = 1'b1;
        state_d   = sts_i.quot_zero ? StEmit : StMul;
      end
      StEmit: begin
        cmd_o.emit = 1'b1;
        if (sts_i.last_digit) begin
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy = (state_q != StIdle);

endmodule

/* rtl/b58enc_dpath.sv */
module b58enc_dpath import b58enc_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  cmd_t                cmd_i,
  output sts_t                sts_o,
  input  logic [NumWidth-1:0] number_i,
  output logic [SymWidth-1:0] symbol_o,
  output logic                final_symbol_o,
  output logic                symbol_valid_o
);

  logic [NumWidth-1:0]  val_q;
  logic [QuotWidth-1:0] quot_q;
  logic [DigWidth-1:0]  dig_q [MaxDigits];
  logic [CntWidth-1:0]  ndig_q;
  logic [SymWidth-1:0]  sym_q;
  logic                 fin_q;
  logic                 vld_q;

  logic [2*NumWidth-1:0] prod;
  logic [NumWidth:0]     quot_x58;
  logic [NumWidth-1:0]   rem_full;
  logic [DigWidth-1:0]   rem;

  assign prod = {{NumWidth{1'b0}}, val_q} * {{NumWidth{1'b0}}, Recip};

  // q * 58 = q*64 - q*4 - q*2
  assign quot_x58 = {quot_q, 6'b0} - {4'b0, quot_q, 2'b0} - {5'b0, quot_q, 1'b0};
  assign rem_full = val_q - quot_x58[NumWidth-1:0];
  assign rem      = rem_full[DigWidth-1:0];

  assign sts_o.quot_zero  = (quot_q == '0);
  assign sts_o.last_digit = (ndig_q == CntWidth'(1));

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      val_q <= number_i;
    end else if (cmd_i.div) begin
      val_q <= {{(NumWidth-QuotWidth){1'b0}}, quot_q};
    end
    if (cmd_i.mul) begin
      quot_q <= prod[2*NumWidth-1:RecipShift];
    end
    // digit stack: push on divide, pop on emit, top at index 0
    if (cmd_i.div) begin
      dig_q[0] <= rem;
      for (int i = 1; i < MaxDigits; i++) begin
        dig_q[i] <= dig_q[i-1];
      end
    end else if (cmd_i.emit) begin
      for (int i = 0; i < MaxDigits - 1; i++) begin
        dig_q[i] <= dig_q[i+1];
      end
    end
    if (cmd_i.emit) begin
      sym_q <= b58_char(dig_q[0]);
      fin_q <= sts_o.last_digit;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ndig_q <= '0;
      vld_q  <= 1'b0;
    end else begin
      vld_q <= cmd_i.emit;
      if (cmd_i.load) begin
        ndig_q <= '0;
      end else if (cmd_i.div) begin
        ndig_q <= ndig_q + CntWidth'(1);
      end else if (cmd_i.emit) begin
        ndig_q <= ndig_q - CntWidth'(1);
      end
    end
  end

  assign symbol_o       = sym_q;
  assign final_symbol_o = fin_q;
  assign symbol_valid_o = vld_q;

endmodule

/* rtl/base58_encode_word.sv */
// Base-58 encoder for one unsigned 32-bit word.
// Input: drive number_i and raise start; the transaction is taken at a
// clock edge where start is high and busy is low. busy stays high until
// the cycle that carries the last character of that value.
// Output: one ASCII character per cycle on symbol_o, most significant
// digit first, qualified by symbol_valid_o; final_symbol_o marks the last
// character. A value of n digits (1..6, zero gives the single '1') yields
// n back-to-back strobes.
// Sequence: each digit passes through the divide loop as a reciprocal
// multiply (StMul), then a remainder step (StDiv); the characters follow
// in the emit sequence (StEmit), each registered before symbol_o. The block
// takes no new value until the divide loop and the emit sequence are done
// and the control is back in idle. The receiver cannot stall; every strobe
// is one transaction.
// Reset: asynchronous, active low; returns to idle and drops the strobe.
module base58_encode_word import b58enc_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  logic [NumWidth-1:0] number_i,
  output logic [SymWidth-1:0] symbol_o,
  output logic                final_symbol_o,
  output logic                symbol_valid_o
);

  cmd_t cmd;
  sts_t sts;

  b58enc_ctrl u_ctrl (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .start (start),
    .busy  (busy),
    .sts_i (sts),
    .cmd_o (cmd)
  );

  b58enc_dpath u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .number_i      (number_i),
    .symbol_o      (symbol_o),
    .final_symbol_o(final_symbol_o),
    .symbol_valid_o(symbol_valid_o)
  );

`ifndef NO_ASSERTIONS
  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy)
    else $error("busy not raised after accepted transaction");

  a_sym_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    symbol_valid_o |-> (symbol_o >= 7'd49) && (symbol_o <= 7'd122))
    else $error("symbol outside alphabet range");

  a_burst: assert property (@(posedge clk_i) disable iff (!rst_ni)
    symbol_valid_o && !final_symbol_o |=> symbol_valid_o)
    else $error("gap inside character burst");

  a_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    symbol_valid_o && final_symbol_o |=> !symbol_valid_o)
    else $error("strobe right after final character");
`endif

endmodule
